/* src/sfcrc_pkg.sv */
// ----------------------------------------------------------------------------
// sfcrc_pkg
// shared widths, frame positions and crc constants for the sensor frame checker
// ----------------------------------------------------------------------------
`default_nettype none

package sfcrc_pkg;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 16;
    localparam int POS_W      = 3;
    localparam int OUT_BITS   = 4 * WORD_W + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // number of leading frame bytes covered by the crc
    localparam logic [POS_W-1:0] CRC_BYTES = 3'd6;

    localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

    // byte positions inside the reply frame
    localparam logic [POS_W-1:0] POS_FIRST   = 3'd0;
    localparam logic [POS_W-1:0] POS_HUM_HI  = 3'd2;
    localparam logic [POS_W-1:0] POS_HUM_LO  = 3'd3;
    localparam logic [POS_W-1:0] POS_TEMP_HI = 3'd4;
    localparam logic [POS_W-1:0] POS_TEMP_LO = 3'd5;
    localparam logic [POS_W-1:0] POS_CRC_LO  = 3'd6;
    localparam logic [POS_W-1:0] POS_CRC_HI  = 3'd7;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [POS_W-1:0]  pos_t;

endpackage : sfcrc_pkg

`default_nettype wire

/* src/sfcrc_crc_step.sv */
// ----------------------------------------------------------------------------
// sfcrc_crc_step
// one-byte update of the reflected crc-16 (poly 0xA001), all eight bit steps
// ----------------------------------------------------------------------------
`default_nettype none

module sfcrc_crc_step
    import sfcrc_pkg::*;
(
    input  word_t      acc_in,
    input  byte_t      data_in,
    input  logic       enable,
    output word_t      acc_out
);

    word_t acc_x;
    word_t stage [0:BYTE_W];

    always_comb begin
        acc_x    = acc_in ^ {{(WORD_W-BYTE_W){1'b0}}, data_in};
        stage[0] = acc_x;
        for (int k = 0; k < BYTE_W; k++) begin
            if (stage[k][0]) begin
                stage[k+1] = (stage[k] >> 1) ^ CRC_POLY;
            end else begin
                stage[k+1] = stage[k] >> 1;
            end
        end
        acc_out = enable ? stage[BYTE_W] : acc_in;
    end

endmodule : sfcrc_crc_step

`default_nettype wire

/* src/sensor_frame_crc_checker_core.sv */
// ----------------------------------------------------------------------------
// sensor_frame_crc_checker_core
// frame checker for an eight-byte humidity/temperature sensor reply
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one reply byte per word on s_tdata, s_tuser high on the first
//   byte of a frame. a marked byte always restarts the frame; unmarked bytes
//   continue at the current position, and after the eighth byte the position
//   wraps so the next byte is byte 0 whatever its mark.
//   m_ channel: one word per completed frame, issued on the eighth byte, with
//   humidity, temperature, received crc, computed crc and the match flag.
//   path: an accepted byte is held in the input register and then processed
//   into the result register, so m_tvalid rises once the eighth byte has
//   moved from the input register into the result register.
//   throughput: one byte per cycle while no eighth byte waits for the result
//   slot; the crc byte update is a single unrolled combinational step between the input and result registers.
//   reset: aresetn low (synchronous) empties both registers, sets the crc to
//   0xFFFF and the byte position to 0.
//   stall: while a result waits on m_tready the block keeps taking bytes;
//   only an eighth byte that finds the result register still full waits in
//   the input register, and s_tready drops until m_tready frees the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_crc_checker_core
    import sfcrc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
    input  logic                   s_tuser,   // [0] frame_start

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] humidity_raw, [31:16] temperature_raw, [47:32] crc_received,
    // [63:48] crc_computed, [64] crc_match, [71:65] zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    // input register
    logic  in_valid_reg;
    byte_t in_byte_reg;
    logic  in_start_reg;

    // frame state
    word_t crc_reg,  crc_next;
    pos_t  pos_reg,  pos_next;
    word_t hum_reg,  hum_next;
    word_t temp_reg, temp_next;
    byte_t crc_lo_reg, crc_lo_next;

    // result register
    logic  out_valid_reg;
    word_t out_hum_reg, out_temp_reg, out_rx_reg, out_crc_reg;
    logic  out_match_reg;

    // effective position and crc after a possible restart mark
    pos_t  pos_cur;
    word_t crc_cur;
    word_t crc_upd;
    word_t crc_rx;
    logic  is_last;
    logic  advance;

    assign pos_cur = in_start_reg ? POS_FIRST : pos_reg;
    assign crc_cur = in_start_reg ? CRC_INIT : crc_reg;
    assign is_last = (pos_cur == POS_CRC_HI);
    assign crc_rx  = {in_byte_reg, crc_lo_reg};

    // an eighth byte needs a free result slot; every other byte moves on
    assign advance  = in_valid_reg && (!is_last || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    sfcrc_crc_step u_crc_step (
        .acc_in  (crc_cur),
        .data_in (in_byte_reg),
        .enable  (pos_cur < CRC_BYTES),
        .acc_out (crc_upd)
    );

    // holds and position for the byte in the input register
    always_comb begin
        hum_next    = hum_reg;
        temp_next   = temp_reg;
        crc_lo_next = crc_lo_reg;
        case (pos_cur)
            POS_HUM_HI:  hum_next    = {in_byte_reg, {BYTE_W{1'b0}}};
            POS_HUM_LO:  hum_next    = {hum_reg[WORD_W-1:BYTE_W], in_byte_reg};
            POS_TEMP_HI: temp_next   = {in_byte_reg, {BYTE_W{1'b0}}};
            POS_TEMP_LO: temp_next   = {temp_reg[WORD_W-1:BYTE_W], in_byte_reg};
            POS_CRC_LO:  crc_lo_next = in_byte_reg;
            default:     ;
        endcase

        if (is_last) begin
            // frame done: wrap and rearm the crc
            pos_next = POS_FIRST;
            crc_next = CRC_INIT;
        end else begin
            pos_next = pos_cur + 3'd1;
            crc_next = crc_upd;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    // frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg    <= CRC_INIT;
            pos_reg    <= POS_FIRST;
            hum_reg    <= '0;
            temp_reg   <= '0;
            crc_lo_reg <= '0;
        end else if (advance) begin
            crc_reg    <= crc_next;
            pos_reg    <= pos_next;
            hum_reg    <= hum_next;
            temp_reg   <= temp_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && is_last) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && is_last) begin
            // the accumulator already holds the crc over the covered bytes
            out_hum_reg   <= hum_reg;
            out_temp_reg  <= temp_reg;
            out_rx_reg    <= crc_rx;
            out_crc_reg   <= crc_upd;
            out_match_reg <= (crc_upd == crc_rx);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, out_match_reg, out_crc_reg,
                       out_rx_reg, out_temp_reg, out_hum_reg};

endmodule : sensor_frame_crc_checker_core

`default_nettype wire

/* src/sfcrc_checker.sv */
// ----------------------------------------------------------------------------
// sfcrc_checker
// port-level checks for the sensor frame crc checker, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module sfcrc_checker
    import sfcrc_pkg::*;
(
    input wire                   aclk,
    input wire                   aresetn,
    input wire                   s_tvalid,
    input wire                   s_tready,
    input wire [BYTE_W-1:0]      s_tdata,
    input wire                   s_tuser,
    input wire                   m_tvalid,
    input wire                   m_tready,
    input wire [OUT_TDATA_W-1:0] m_tdata
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

    // match flag agrees with the two crc fields
    a_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_BITS-1] == (m_tdata[63:48] == m_tdata[47:32])))
        else $error("crc match flag inconsistent");

    // pad bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_TDATA_W-1:OUT_BITS] == '0))
        else $error("result padding not zero");

    // a fresh result follows a byte that was accepted and then passed through the input register
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a preceding byte");

endmodule : sfcrc_checker

bind sensor_frame_crc_checker_core sfcrc_checker u_sfcrc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
